// ----- hw/rtl/cld_pkg.sv -----
// Shared types and constants for the Content-Length deframer.
// No dependencies; the top, the parser and the bench import this package.
`default_nettype none

package cld_pkg;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_SKIPWS = 3'd1,
		PH_DIGITS = 3'd2,
		PH_TAIL   = 3'd3,
		PH_BODY   = 3'd4
	} phase_t;

	// Result kinds carried on the output channel.
	typedef enum logic [1:0] {
		KIND_BODY  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam int unsigned KEY_LEN = 15;
	localparam int unsigned MAX_LEN_BITS = 31;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_SP = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	// One result word handed from the parser to the output register.
	typedef struct packed {
		logic       valid;
		logic [7:0] body_byte;
		logic       last_of_message;
		kind_t      kind;
	} cld_result_t;

	// Characters of the "Content-Length:" key by position.
	function automatic logic [7:0] key_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0: c = "C";
			4'd1: c = "o";
			4'd2: c = "n";
			4'd3: c = "t";
			4'd4: c = "e";
			4'd5: c = "n";
			4'd6: c = "t";
			4'd7: c = "-";
			4'd8: c = "L";
			4'd9: c = "e";
			4'd10: c = "n";
			4'd11: c = "g";
			4'd12: c = "t";
			4'd13: c = "h";
			4'd14: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cld_if.sv -----
// Valid/ready channel interfaces for the deframer: raw stream in, results out.
// Depends on nothing; the payload kind code is defined in cld_pkg.
`default_nettype none

// Raw byte stream channel.
interface cld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

// Message result channel.
interface cld_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       last_of_message;
	logic [1:0] kind;

	modport source (output valid, output body_byte, output last_of_message, output kind,
		input ready);
	modport sink (input valid, input body_byte, input last_of_message, input kind,
		output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/content_length_deframer_top.sv -----
// Top level of the Content-Length deframer: input register, parser, result register.
// Depends on cld_pkg, cld_if (cld_byte_if, cld_msg_if) and cld_parser.
//
// Usage: raw bytes arrive on the stream channel, one word per valid/ready
// handshake. The header is searched for the first "Content-Length:" key,
// whose decimal value (after optional whitespace) gives the body length;
// CR LF CR LF ends the header. The message channel then carries each body
// byte as a word of kind 0, with last_of_message on the final byte. A zero
// length gives one word of kind 1, and a header without a usable length
// (no key, no digits, or a value above max_body_length) gives one word of
// kind 2; both have last_of_message set. Header bytes give no word.
// Throughput is one byte per cycle while message.ready stays high. A
// byte passes the input register and the parser into the result register,
// which offers its word. When the receiver stalls, the result register
// holds its word and the input register keeps one more byte; stream.ready
// falls only when both are full. Reset clears the parser to key hunting,
// empties both registers and sets max_body_length to its largest value.
// The user writes the register with max_body_length_we only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module content_length_deframer_top
	import cld_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	cld_byte_if.sink                     stream,
	cld_msg_if.source                    message,
	input  wire logic                    max_body_length_we,
	input  wire logic [MAX_LEN_BITS-1:0] max_body_length
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    advance;
	logic [MAX_LEN_BITS-1:0] max_len_q;
	cld_result_t             result;
	logic                    out_valid_q;
	logic [7:0]              body_byte_q;
	logic                    last_q;
	kind_t                   kind_q;

	// The registered byte moves on when the result register is free or draining.
	assign advance = valid_s1 && (!out_valid_q || message.ready);
	assign stream.ready = !valid_s1 || advance;

	// Length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
		end else if (max_body_length_we) begin
			max_len_q <= max_body_length;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.stream_byte;
		end
	end

	cld_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.byte_in (byte_s1),
		.max_len (max_len_q),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (message.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			body_byte_q <= result.body_byte;
			last_q <= result.last_of_message;
			kind_q <= result.kind;
		end
	end

	assign message.valid = out_valid_q;
	assign message.body_byte = body_byte_q;
	assign message.last_of_message = last_q;
	assign message.kind = kind_q;

endmodule

`default_nettype wire

// ----- hw/rtl/cld_parser.sv -----
// Header parser and body counter of the deframer: holds the parse state and
// turns one registered byte per enabled cycle into at most one result. Uses cld_pkg.
`default_nettype none

module cld_parser
	import cld_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic [7:0]              byte_in,
	input  wire logic [MAX_LEN_BITS-1:0] max_len,
	output cld_result_t                  result
);

	// Width that holds ten times the accumulator plus a digit, and the limit.
	localparam int unsigned CW = (LENGTH_BITS + 4 > MAX_LEN_BITS)
		? LENGTH_BITS + 4 : MAX_LEN_BITS;

	phase_t                 phase_q, phase_n;
	logic [3:0]             key_pos_q, key_pos_n;
	logic [1:0]             hep_q, hep_n;
	logic [LENGTH_BITS-1:0] acc_q, acc_n;
	logic                   has_digit_q, has_digit_n;
	logic                   too_large_q, too_large_n;
	logic [LENGTH_BITS-1:0] left_q, left_n;

	logic                   header_done;
	logic                   is_digit;
	logic                   is_ws;
	logic [CW-1:0]          acc_w;
	logic [CW-1:0]          next_w;
	logic                   next_big;
	logic [LENGTH_BITS-1:0] left_dec;

	// Character classes and the digit step of the length value.
	always_comb begin
		is_digit = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);
		is_ws = (byte_in == CHAR_SP) || ((byte_in >= CHAR_TAB) && (byte_in <= CHAR_CR));
		acc_w = CW'(acc_q);
		next_w = (acc_w << 3) + (acc_w << 1) + CW'(byte_in[3:0]);
		next_big = ((next_w >> LENGTH_BITS) != '0) || (next_w > CW'(max_len));
		left_dec = left_q - LENGTH_BITS'(1);
	end

	// Next state.
	always_comb begin
		phase_n = phase_q;
		key_pos_n = key_pos_q;
		hep_n = hep_q;
		acc_n = acc_q;
		has_digit_n = has_digit_q;
		too_large_n = too_large_q;
		left_n = left_q;
		header_done = 1'b0;

		if (phase_q == PH_BODY) begin
			left_n = left_dec;
			if (left_dec == '0) begin
				phase_n = PH_HUNT;
				key_pos_n = '0;
				hep_n = '0;
				acc_n = '0;
				has_digit_n = 1'b0;
				too_large_n = 1'b0;
			end
		end else begin
			// Track the CR LF CR LF that ends the header.
			if (byte_in == CHAR_CR) begin
				hep_n = (hep_q == 2'd2) ? 2'd3 : 2'd1;
			end else if (byte_in == CHAR_LF) begin
				header_done = (hep_q == 2'd3);
				hep_n = (hep_q == 2'd1) ? 2'd2 : 2'd0;
			end else begin
				hep_n = 2'd0;
			end

			case (phase_q)
				PH_HUNT: begin
					if (byte_in == key_char(key_pos_q)) begin
						if (key_pos_q == 4'(KEY_LEN - 1)) begin
							key_pos_n = '0;
							phase_n = PH_SKIPWS;
						end else begin
							key_pos_n = key_pos_q + 4'd1;
						end
					end else begin
						key_pos_n = (byte_in == key_char(4'd0)) ? 4'd1 : 4'd0;
					end
				end
				PH_SKIPWS, PH_DIGITS: begin
					if (is_digit) begin
						has_digit_n = 1'b1;
						phase_n = PH_DIGITS;
						if (!too_large_q) begin
							if (next_big) begin
								too_large_n = 1'b1;
							end else begin
								acc_n = next_w[LENGTH_BITS-1:0];
							end
						end
					end else if (!(is_ws && phase_q == PH_SKIPWS)) begin
						phase_n = PH_TAIL;
					end
				end
				default: begin
				end
			endcase

			// At the header end, start a body or go back to hunting.
			if (header_done) begin
				if (phase_n != PH_HUNT && has_digit_n && !too_large_n && acc_n != '0) begin
					left_n = acc_n;
					phase_n = PH_BODY;
				end else begin
					phase_n = PH_HUNT;
				end
				key_pos_n = '0;
				hep_n = '0;
				acc_n = '0;
				has_digit_n = 1'b0;
				too_large_n = 1'b0;
			end
		end
	end

	// Result word for this byte.
	always_comb begin
		result = '0;
		result.kind = KIND_BODY;
		if (en) begin
			if (phase_q == PH_BODY) begin
				result.valid = 1'b1;
				result.body_byte = byte_in;
				result.last_of_message = (left_dec == '0);
			end else if (header_done) begin
				if (phase_n == PH_HUNT) begin
					result.valid = 1'b1;
					result.last_of_message = 1'b1;
					// The closing LF leaves the length fields as they were, so the
					// stored values tell an empty message from a header error.
					result.kind = KIND_ERROR;
					if (phase_q != PH_HUNT && has_digit_q && !too_large_q) begin
						result.kind = KIND_EMPTY;
					end
				end
			end
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			key_pos_q <= '0;
			hep_q <= '0;
			acc_q <= '0;
			has_digit_q <= 1'b0;
			too_large_q <= 1'b0;
			left_q <= '0;
		end else if (en) begin
			phase_q <= phase_n;
			key_pos_q <= key_pos_n;
			hep_q <= hep_n;
			acc_q <= acc_n;
			has_digit_q <= has_digit_n;
			too_large_q <= too_large_n;
			left_q <= left_n;
		end
	end

endmodule

`default_nettype wire

// ----- bench/content_length_deframer_top_test.sv -----
// Self-checking bench for content_length_deframer_top: framed byte streams in, words out.
// Depends on cld_pkg, the cld_byte_if/cld_msg_if interfaces and the deframer RTL.
// A built-in predictor of the parser checks every output word in order.

module content_length_deframer_top_test
	import cld_pkg::*;
();

	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_BYTES = 950;
	localparam int PHASE_COUNT = 7;
	localparam logic [30:0] MAX_LENGTH_TOP = 31'h7FFF_FFFF;
	localparam logic [8*15-1:0] KEY_TEXT = "Content-Length:";
	localparam string HDR_END = "\015\012\015\012";

	// One expected word on the message channel.
	typedef struct packed {
		logic [7:0] body_byte;
		logic       last_of_message;
		kind_t      kind;
	} msg_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic [7:0] src_byte = 8'h00;
	logic snk_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic [MAX_LEN_BITS-1:0] cfg_value = MAX_LENGTH_TOP;

	cld_byte_if stream_ch();
	cld_msg_if message_ch();

	assign stream_ch.valid = src_valid;
	assign stream_ch.stream_byte = src_byte;
	assign message_ch.ready = snk_ready;

	content_length_deframer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_ch),
		.message(message_ch),
		.max_body_length_we(cfg_we),
		.max_body_length(cfg_value)
	);

	always #5 clk = ~clk;

	// Bytes waiting to be sent and words waiting to be seen.
	logic [7:0] stream_bytes_pending[$];
	msg_word_t expected_words[$];
	int bytes_queued = 0;
	int bytes_accepted = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	logic stream_taken = 1'b0;

	// Idle controls for both sides.
	bit src_gaps_on = 1'b0;
	bit snk_stalls_on = 1'b0;
	int src_gap_left = 0;
	int snk_stall_left = 0;
	int hold_left = 0;
	int hold_request = 0;

	// Predictor copy of the parser state and the length register.
	logic [30:0] model_max = MAX_LENGTH_TOP;
	phase_t m_phase = PH_HUNT;
	logic [3:0] m_key_pos = '0;
	logic [1:0] m_crlf = '0;
	logic [31:0] m_length = '0;
	logic m_has_digit = 1'b0;
	logic m_too_large = 1'b0;
	logic [31:0] m_body_left = '0;

	task automatic report_mismatch(input string what);
		$display("ERROR cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic clear_header();
		m_phase = PH_HUNT;
		m_key_pos = '0;
		m_crlf = '0;
		m_length = '0;
		m_has_digit = 1'b0;
		m_too_large = 1'b0;
	endtask

	// Each digit is checked against the register value of the moment.
	task automatic take_digit(input logic [7:0] b);
		logic [63:0] next_len;
		m_has_digit = 1'b1;
		if (!m_too_large) begin
			next_len = 64'(m_length) * 10 + 64'(b - CHAR_ZERO);
			if (next_len > 64'(model_max))
				m_too_large = 1'b1;
			else
				m_length = next_len[31:0];
		end
	endtask

	// Advance the predicted parser by one accepted byte.
	task automatic predict_byte(input logic [7:0] b);
		logic header_done;
		logic is_digit;
		header_done = 1'b0;
		is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		if (m_phase == PH_BODY) begin
			m_body_left = m_body_left - 1;
			if (m_body_left == 0) begin
				clear_header();
				expected_words.push_back('{b, 1'b1, KIND_BODY});
			end else begin
				expected_words.push_back('{b, 1'b0, KIND_BODY});
			end
			return;
		end

		// Track the CR LF CR LF that closes the header.
		if (b == CHAR_CR) begin
			m_crlf = (m_crlf == 2'd2) ? 2'd3 : 2'd1;
		end else if (b == CHAR_LF) begin
			header_done = (m_crlf == 2'd3);
			m_crlf = (m_crlf == 2'd1) ? 2'd2 : 2'd0;
		end else begin
			m_crlf = 2'd0;
		end

		case (m_phase)
			PH_HUNT: begin
				if (m_key_pos < KEY_LEN && b == KEY_TEXT[8*(KEY_LEN-1-m_key_pos) +: 8])
					m_key_pos = m_key_pos + 4'd1;
				else
					m_key_pos = (b == KEY_TEXT[8*(KEY_LEN-1) +: 8]) ? 4'd1 : 4'd0;
				if (m_key_pos >= KEY_LEN) begin
					m_key_pos = '0;
					m_phase = PH_SKIPWS;
				end
			end
			PH_SKIPWS: begin
				if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))) begin
					if (is_digit) begin
						take_digit(b);
						m_phase = PH_DIGITS;
					end else begin
						m_phase = PH_TAIL;
					end
				end
			end
			PH_DIGITS: begin
				if (is_digit)
					take_digit(b);
				else
					m_phase = PH_TAIL;
			end
			default: ;
		endcase

		if (!header_done)
			return;
		if (m_phase == PH_HUNT || !m_has_digit || m_too_large) begin
			clear_header();
			expected_words.push_back('{8'h00, 1'b1, KIND_ERROR});
		end else if (m_length == 0) begin
			clear_header();
			expected_words.push_back('{8'h00, 1'b1, KIND_EMPTY});
		end else begin
			m_body_left = m_length;
			clear_header();
			m_phase = PH_BODY;
		end
	endtask

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Output check first, then prediction for the byte taken at this edge.
	always @(posedge clk) begin : monitor
		msg_word_t want;
		if (message_ch.valid && message_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("output word with nothing expected");
			end else begin
				want = expected_words.pop_front();
				if (message_ch.body_byte !== want.body_byte)
					report_mismatch($sformatf("body_byte %h, expected %h",
						message_ch.body_byte, want.body_byte));
				if (message_ch.last_of_message !== want.last_of_message)
					report_mismatch($sformatf("last_of_message %b, expected %b",
						message_ch.last_of_message, want.last_of_message));
				if (message_ch.kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d",
						message_ch.kind, want.kind));
			end
		end
		if (stream_ch.valid && stream_ch.ready) begin
			predict_byte(stream_ch.stream_byte);
			bytes_accepted <= bytes_accepted + 1;
		end
		stream_taken <= stream_ch.valid && stream_ch.ready;
	end

	// Sender: offers the next pending byte once the last one was taken.
	always @(negedge clk) begin
		if (arst_n && (!src_valid || stream_taken)) begin
			if (src_gap_left > 0) begin
				src_valid <= 1'b0;
				src_gap_left <= src_gap_left - 1;
			end else if (stream_bytes_pending.size() > 0) begin
				src_byte <= stream_bytes_pending.pop_front();
				src_valid <= 1'b1;
				src_gap_left <= src_gaps_on ? idle_length() : 0;
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			snk_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request > 0) begin
			snk_ready <= 1'b0;
			hold_left <= hold_request - 1;
			hold_request = 0;
		end else if (snk_stall_left > 0) begin
			snk_ready <= 1'b0;
			snk_stall_left <= snk_stall_left - 1;
		end else begin
			snk_ready <= 1'b1;
			snk_stall_left <= snk_stalls_on ? idle_length() : 0;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		stream_bytes_pending.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_text(input string s);
		foreach (s[i])
			push_byte(s[i]);
	endtask

	task automatic push_body(input int n);
		repeat (n)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	// Wait until every byte is taken and every word seen, then let the pipe settle.
	task automatic wait_idle();
		while (bytes_accepted != bytes_queued || expected_words.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_max_length(input logic [30:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_value <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		model_max = value;
	endtask

	// One random frame: mostly well formed, the rest broken headers and noise.
	task automatic push_random_frame();
		int r;
		int len;
		logic [63:0] big;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case ($urandom_range(0, 3))
				0: push_text("Content-Type: text\015\012");
				1: push_text("X: Content-Len\015\012");
				2: push_text("Content-length: 9\015\012");
				default: ;
			endcase
			push_text("Content-Length:");
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 3))
					0: push_byte(8'h20);
					1: push_byte(8'h09);
					2: push_byte(8'h0B);
					default: push_byte(8'h0C);
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				len = 0;
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(13, 40);
			else
				len = $urandom_range(1, 12);
			if ($urandom_range(0, 7) == 0)
				push_text("00");
			push_text($sformatf("%0d", len));
			case ($urandom_range(0, 3))
				0: push_text(";x");
				1: push_text(" \011z");
				default: ;
			endcase
			push_text(HDR_END);
			if (len <= model_max)
				push_body(len);
		end else if (r < 80) begin
			push_text($urandom_range(0, 1) ? {"Host: a", HDR_END} : {"Content-Len", HDR_END});
		end else if (r < 87) begin
			push_text($urandom_range(0, 1) ? {"Content-Length: x", HDR_END}
				: {"Content-Length:-7", HDR_END});
		end else if (r < 93) begin
			big = 64'(model_max) + 1 + $urandom_range(0, 9);
			push_text({"Content-Length: ", $sformatf("%0d", big), HDR_END});
		end else begin
			push_body($urandom_range(1, 10));
			push_text(HDR_END);
		end
	endtask

	initial begin : stimulus
		logic [30:0] phase_max[PHASE_COUNT];
		int phase_target;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed frames at the reset value of the length register.
		push_text({"Content-Length: 3", HDR_END});
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h0D);
		push_text({"Content-Length:0", HDR_END});
		push_text({"Host: x", HDR_END});
		push_text({"Content-Length:\011", HDR_END});
		push_text({"Content-Length: +5", HDR_END});
		push_text({"Content-Length: 2-1", HDR_END});
		push_text("\015\012");
		push_text({"Content-Length:\013\014\015\0124 tail", HDR_END});
		push_body(4);
		push_text({"CContent-LengtContent-Length: 1\015\012Content-Length: 9", HDR_END});
		push_body(1);
		push_text({"Content-Length: 99999999999", HDR_END});
		push_text({"Content-Length: 4294967296", HDR_END});
		push_text({"Content-Length: 2147483648", HDR_END});
		wait_idle();

		// Register changes in the middle of a header.
		push_text("Content-Length: 1");
		wait_idle();
		write_max_length(31'd10);
		push_text({"2", HDR_END});
		push_text("Content-Length: 1");
		wait_idle();
		write_max_length(31'd12);
		push_text({"2", HDR_END});
		push_body(12);
		wait_idle();

		// Receiver holds off while the sender keeps streaming a long body.
		@(posedge clk);
		hold_request = 60;
		push_text({"Content-Length: 40", HDR_END});
		push_body(40);
		wait_idle();

		// Random phases, each under its own length register setting.
		phase_max[0] = 31'd0;
		phase_max[1] = 31'd5;
		phase_max[2] = 31'($urandom_range(1, 40));
		phase_max[3] = 31'd255;
		phase_max[4] = 31'($urandom_range(0, 32'h7FFF_FFFF));
		phase_max[5] = 31'd12;
		phase_max[6] = MAX_LENGTH_TOP;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_max_length(phase_max[p]);
			src_gaps_on = (p == 1) || ($urandom_range(0, 3) != 0);
			snk_stalls_on = (p == 1) || ($urandom_range(0, 3) != 0);
			phase_target = bytes_queued + RANDOM_BYTES / PHASE_COUNT;
			while (bytes_queued < phase_target)
				push_random_frame();
			wait_idle();
		end

		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
